[rtl/kslpc_pkg.sv]
// Shared constants for the key short/long press classifier.
// No dependencies; used by key_short_long_press_classifier_core.
package kslpc_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned EVT_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // press event codes
    localparam logic [EVT_W-1:0] EVT_NONE  = 2'd0;
    localparam logic [EVT_W-1:0] EVT_SHORT = 2'd1;
    localparam logic [EVT_W-1:0] EVT_LONG  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT    = 2'd1;

    // register reset values and the tick counter maximum
    localparam logic [TICK_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [TICK_W-1:0] LOCKOUT_RST    = 16'd200;
    localparam logic [TICK_W-1:0] TICK_MAX       = 16'hFFFF;

endpackage

[rtl/key_short_long_press_classifier_core.sv]
// Key short/long press classifier: one key sample per tick in, one event word out.
// Depends on kslpc_pkg for widths, event codes and register indexes.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------
//  in       | i_in_valid / o_in_stall     | i_key_level
//  out      | o_out_valid / i_out_stall   | o_press_event, o_locked_out
//  cfg      | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A sample is taken each cycle unless the input stalls; its result word is registered.
// The state update is a single combinational pass into the state and result
// registers, so throughput is one word per cycle, limited only by output stall.
// Input stalls only while a result word is held and the output side stalls.
// Synchronous active-low reset restores the register and key state defaults.
module key_short_long_press_classifier_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_key_level,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [kslpc_pkg::EVT_W-1:0]         o_press_event,
    output logic                                o_locked_out,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kslpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kslpc_pkg::TICK_W-1:0]        i_cfg_data
);

    logic                          w_in_accept;

    logic [kslpc_pkg::TICK_W-1:0]  r_long_ticks;
    logic [kslpc_pkg::TICK_W-1:0]  r_lockout_ticks;

    logic                          r_prev_level,     n_prev_level;
    logic                          r_await_press,    n_await_press;
    logic                          r_key_enabled,    n_key_enabled;
    logic                          r_swallow,        n_swallow;
    logic                          r_timer_running,  n_timer_running;
    logic [kslpc_pkg::TICK_W-1:0]  r_timer_remaining, n_timer_remaining;
    logic [kslpc_pkg::TICK_W-1:0]  r_held_ticks,     n_held_ticks;
    logic [kslpc_pkg::EVT_W-1:0]   n_event;

    logic                          r_out_valid;
    logic [kslpc_pkg::EVT_W-1:0]   r_press_event;
    logic                          r_locked_out;

    // accept a sample whenever the result register is free or draining
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_in_accept = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid   = r_out_valid;
    assign o_press_event = r_press_event;
    assign o_locked_out  = r_locked_out;

    // capture configuration words; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks    <= kslpc_pkg::LONG_PRESS_RST;
            r_lockout_ticks <= kslpc_pkg::LOCKOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kslpc_pkg::CFG_LONG_PRESS: r_long_ticks    <= i_cfg_data;
                kslpc_pkg::CFG_LOCKOUT:    r_lockout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // one tick: edge handling first, then the one-shot timer, then elapsed count
    always_comb begin
        n_prev_level      = r_prev_level;
        n_await_press     = r_await_press;
        n_key_enabled     = r_key_enabled;
        n_swallow         = r_swallow;
        n_timer_running   = r_timer_running;
        n_timer_remaining = r_timer_remaining;
        n_held_ticks      = r_held_ticks;
        n_event           = kslpc_pkg::EVT_NONE;

        if (w_in_accept) begin
            // edge logic; while disabled, only a pending swallowed edge is taken, others are ignored
            if (i_key_level != r_prev_level) begin
                if (r_swallow) begin
                    n_swallow     = 1'b0;
                    n_await_press = 1'b1;
                end else if (r_key_enabled) begin
                    if (r_await_press) begin
                        if (!i_key_level) begin
                            n_await_press     = 1'b0;
                            n_timer_running   = 1'b1;
                            n_timer_remaining = r_long_ticks;
                            n_held_ticks      = '0;
                        end
                    end else if (i_key_level) begin
                        n_await_press = 1'b1;
                        if (r_held_ticks < r_long_ticks) begin
                            n_event           = kslpc_pkg::EVT_SHORT;
                            n_key_enabled     = 1'b0;
                            n_timer_running   = 1'b1;
                            n_timer_remaining = r_lockout_ticks;
                        end
                    end
                end
            end
            n_prev_level = i_key_level;

            // timer: a remaining count of zero or one expires this tick
            if (n_timer_running) begin
                if (n_timer_remaining <= kslpc_pkg::TICK_W'(1)) begin
                    n_timer_remaining = '0;
                    n_timer_running   = 1'b0;
                    if (n_key_enabled) begin
                        n_key_enabled     = 1'b0;
                        n_swallow         = 1'b1;
                        n_event           = kslpc_pkg::EVT_LONG;
                        n_timer_running   = 1'b1;
                        n_timer_remaining = r_lockout_ticks;
                    end else begin
                        n_key_enabled = 1'b1;
                    end
                end else begin
                    n_timer_remaining = n_timer_remaining - kslpc_pkg::TICK_W'(1);
                end
            end

            // saturating elapsed counter
            if (n_held_ticks != kslpc_pkg::TICK_MAX) begin
                n_held_ticks = n_held_ticks + kslpc_pkg::TICK_W'(1);
            end
        end
    end

    // key state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level      <= 1'b1;
            r_await_press     <= 1'b1;
            r_key_enabled     <= 1'b1;
            r_swallow         <= 1'b0;
            r_timer_running   <= 1'b0;
            r_timer_remaining <= '0;
            r_held_ticks      <= '0;
        end else begin
            r_prev_level      <= n_prev_level;
            r_await_press     <= n_await_press;
            r_key_enabled     <= n_key_enabled;
            r_swallow         <= n_swallow;
            r_timer_running   <= n_timer_running;
            r_timer_remaining <= n_timer_remaining;
            r_held_ticks      <= n_held_ticks;
        end
    end

    // result word valid: set on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded with each accepted sample
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_press_event <= n_event;
            r_locked_out  <= ~n_key_enabled;
        end
    end

`ifndef SYNTHESIS
    // a reported long press always leaves the key locked out; a short press
    // with a one-tick lockout may already be re-enabled in the same tick
    a_event_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_press_event == kslpc_pkg::EVT_LONG)) |-> r_locked_out)
        else $error("long press reported without lockout");

    // a stopped timer holds zero
    a_timer_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_timer_running |-> (r_timer_remaining == '0))
        else $error("stopped timer holds a count");

    // a disabled key always has its lockout timer running
    a_lockout_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_key_enabled |-> r_timer_running)
        else $error("key disabled with no timer running");

    // the held result word tracks the live lockout state
    a_locked_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_locked_out == !r_key_enabled))
        else $error("locked_out disagrees with key state");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking bench for key_short_long_press_classifier_core: key samples in,
// press event words out, predicted on the fly and compared word by word.
// Depends on kslpc_pkg and the core RTL only.
module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct packed {
        logic [kslpc_pkg::EVT_W-1:0] evt;
        logic                        locked;
    } t_press_word;

    // Tracks the key state, predicts one word per accepted sample and
    // checks the words that come out against that prediction.
    class press_scoreboard;
        logic [kslpc_pkg::TICK_W-1:0] long_press_ticks;
        logic [kslpc_pkg::TICK_W-1:0] lockout_ticks;
        logic                         prior_level;
        bit                           armed;
        bit                           key_live;
        bit                           skip_edge;
        bit                           countdown_on;
        logic [kslpc_pkg::TICK_W-1:0] countdown;
        logic [kslpc_pkg::TICK_W-1:0] press_age;
        t_press_word                  expected_words[$];
        int unsigned                  mismatches;
        int unsigned                  samples_seen;
        int unsigned                  words_checked;
        int unsigned                  shorts_seen;
        int unsigned                  longs_seen;
        int unsigned                  reg_writes;

        function new();
            long_press_ticks = kslpc_pkg::LONG_PRESS_RST;
            lockout_ticks    = kslpc_pkg::LOCKOUT_RST;
            prior_level      = 1'b1;
            armed            = 1'b1;
            key_live         = 1'b1;
            skip_edge        = 1'b0;
            countdown_on     = 1'b0;
            countdown        = '0;
            press_age        = '0;
        endfunction

        function void write_reg(logic [kslpc_pkg::CFG_IDX_W-1:0] idx,
                                logic [kslpc_pkg::TICK_W-1:0] val);
            reg_writes++;
            case (idx)
                kslpc_pkg::CFG_LONG_PRESS: long_press_ticks = val;
                kslpc_pkg::CFG_LOCKOUT:    lockout_ticks = val;
                default: ;
            endcase
        endfunction

        // Advance the key state by one tick and queue the word it yields.
        function void note_sample(logic level);
            t_press_word w;
            w.evt = kslpc_pkg::EVT_NONE;
            samples_seen++;
            // edge logic runs before the timer
            if (level != prior_level) begin
                if (skip_edge) begin
                    skip_edge = 1'b0;
                    armed = 1'b1;
                end else if (key_live) begin
                    if (armed) begin
                        if (level == 1'b0) begin
                            armed = 1'b0;
                            countdown_on = 1'b1;
                            countdown = long_press_ticks;
                            press_age = '0;
                        end
                    end else if (level == 1'b1) begin
                        armed = 1'b1;
                        if (press_age < long_press_ticks) begin
                            w.evt = kslpc_pkg::EVT_SHORT;
                            key_live = 1'b0;
                            countdown_on = 1'b1;
                            countdown = lockout_ticks;
                        end
                    end
                end
            end
            prior_level = level;
            // one-shot timer: long press while enabled, re-enable during lockout
            if (countdown_on) begin
                if (countdown <= 1) begin
                    countdown = '0;
                    countdown_on = 1'b0;
                    if (key_live) begin
                        key_live = 1'b0;
                        skip_edge = 1'b1;
                        w.evt = kslpc_pkg::EVT_LONG;
                        countdown_on = 1'b1;
                        countdown = lockout_ticks;
                    end else begin
                        key_live = 1'b1;
                    end
                end else begin
                    countdown = countdown - 1'b1;
                end
            end
            if (press_age != kslpc_pkg::TICK_MAX)
                press_age = press_age + 1'b1;
            w.locked = !key_live;
            if (w.evt == kslpc_pkg::EVT_SHORT) shorts_seen++;
            if (w.evt == kslpc_pkg::EVT_LONG) longs_seen++;
            expected_words.push_back(w);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH @%0t: %s", $time, what);
        endtask

        task check_word(logic [kslpc_pkg::EVT_W-1:0] evt, logic locked);
            t_press_word want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("word with nothing pending: event=%0d locked=%0d",
                                          evt, locked));
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (evt !== want.evt)
                report_mismatch($sformatf("word %0d press_event got %0d want %0d",
                                          words_checked, evt, want.evt));
            if (locked !== want.locked)
                report_mismatch($sformatf("word %0d locked_out got %0d want %0d",
                                          words_checked, locked, want.locked));
        endtask
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic                                i_key_level = 1'b1;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [kslpc_pkg::EVT_W-1:0]         o_press_event;
    logic                                o_locked_out;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [kslpc_pkg::CFG_IDX_W-1:0]     i_cfg_index = kslpc_pkg::CFG_LONG_PRESS;
    logic [kslpc_pkg::TICK_W-1:0]        i_cfg_data = '0;

    press_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  pressure_req = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  input_stall_cycles = 0;

    key_short_long_press_classifier_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_key_level  (i_key_level),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_press_event(o_press_event),
        .o_locked_out (o_locked_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check accepted words, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word(o_press_event, o_locked_out);
        if (hold_left == 0 && pressure_req) begin
            hold_left = HOLD_OFF_CYCLES;
            pressure_req = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: end the run when no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (i_rst_n && i_in_valid && o_in_stall)
            input_stall_cycles <= input_stall_cycles + 1;
    end

    // Offer one sample after a random gap and hold it until accepted.
    task automatic send_sample(input logic level);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_key_level <= level;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_sample(level);
    endtask

    // Drain the block, then write both registers back to back.
    task automatic program_regs(input logic [kslpc_pkg::TICK_W-1:0] long_v,
                                input logic [kslpc_pkg::TICK_W-1:0] lock_v);
        logic [kslpc_pkg::CFG_IDX_W-1:0] idx[2];
        logic [kslpc_pkg::TICK_W-1:0]    val[2];
        idx[0] = kslpc_pkg::CFG_LONG_PRESS;
        idx[1] = kslpc_pkg::CFG_LOCKOUT;
        val[0] = long_v;
        val[1] = lock_v;
        i_in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        for (int r = 0; r < 2; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[r];
            i_cfg_data  <= val[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.write_reg(idx[r], val[r]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly clean press/release pairs sized around the current registers,
    // with some contact bounce mixed in.
    task automatic run_presses(input int budget);
        int sent;
        int pick;
        int press_len;
        int rel_len;
        int span;
        int lp;
        int lk;
        sent = 0;
        lp = int'(sb.long_press_ticks);
        lk = int'(sb.lockout_ticks);
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                span = $urandom_range(1, 4);
                for (int k = 0; k < span; k++) send_sample(1'($urandom_range(1)));
                sent += span;
            end else begin
                if (pick < 50)
                    press_len = $urandom_range(1, (lp > 1) ? ((lp - 1 < 60) ? lp - 1 : 60) : 1);
                else if (pick < 70)
                    press_len = lp - 1 + $urandom_range(2);
                else
                    press_len = lp + $urandom_range(1, 30);
                if (press_len < 1) press_len = 1;
                if (press_len > 200) press_len = $urandom_range(100, 200);
                rel_len = $urandom_range(1, (lk + 8 < 80) ? lk + 8 : 80);
                repeat (press_len) send_sample(1'b0);
                repeat (rel_len) send_sample(1'b1);
                sent += press_len + rel_len;
            end
        end
    endtask

    initial begin
        logic [kslpc_pkg::TICK_W-1:0] lv;
        logic [kslpc_pkg::TICK_W-1:0] kv;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: short press, edges ignored in lockout, long press, swallowed edge
        send_idle_pct  = 14;
        recv_stall_pct = 61;
        program_regs(16'd3, 16'd2);
        repeat (2) send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
        repeat (2) send_sample(1'b1);
        repeat (5) send_sample(1'b0);
        repeat (3) send_sample(1'b1);

        // shrink the long-press time mid-press: release reports nothing,
        // the running timer reports the long press later
        program_regs(16'd10, 16'd2);
        repeat (4) send_sample(1'b0);
        program_regs(16'd2, 16'd2);
        repeat (7) send_sample(1'b1);
        repeat (2) send_sample(1'b0);
        repeat (2) send_sample(1'b1);

        // random phases over several settings and three idling modes
        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct  = (ph < 3) ? 14 : (ph < 6) ? 61 : 0;
            recv_stall_pct = (ph < 3) ? 61 : (ph < 6) ? 14 : 0;
            lv = 16'($urandom_range(2, 40));
            kv = 16'($urandom_range(1, 30));
            case (ph)
                0: begin
                    lv = 16'd1;
                    kv = 16'd1;
                end
                1: kv = 16'd1;
                7: lv = 16'($urandom_range(1000, 65535));
                8: begin
                    lv = kslpc_pkg::TICK_MAX;
                    kv = kslpc_pkg::TICK_MAX;
                end
                default: ;
            endcase
            if (ph == 1) lv = kslpc_pkg::TICK_MAX;
            program_regs(lv, kv);
            if (ph == 0) pressure_req = 1'b1;
            run_presses(160);
        end

        // let the last words drain
        i_in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Run: %0d samples, %0d words checked, %0d short and %0d long presses",
                 sb.samples_seen, sb.words_checked, sb.shorts_seen, sb.longs_seen);
        $display("     %0d register writes, %0d input stall cycles, %0d mismatches",
                 sb.reg_writes, input_stall_cycles, sb.mismatches);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
